// ----- rtl/hcpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hcpc_pkg: shared types and constants of the hot/cold pixel corrector
// Sample widths, register indexes, mode and class codes, the median helper.
// ----------------------------------------------------------------------------
package hcpc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int ITEM_BITS  = PIXEL_BITS + 1;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int FW_BITS    = 13;
  localparam int ROW_BITS   = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [ITEM_BITS-1:0]  item_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAW_CFA   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLD_THR  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_THR   = 3'd5;

  // modes
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_DEFECT = 2'd1;
  localparam logic [1:0] MODE_SIGMA  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;  // unused, passes through

  // result classes
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_HOT    = 2'd1;
  localparam logic [1:0] CLS_COLD   = 2'd2;
  localparam logic [1:0] CLS_DEFECT = 2'd3;

  // per-item bookkeeping carried down the pipe
  typedef struct packed {
    logic emit;
    logic last;
    col_t x;
    row_t y;
  } pos_t;

  // mean of the 4th and 5th smallest of eight samples, rounded half up
  // odd-even transposition sort, eight rounds
  function automatic pix_t median8(input logic [7:0][PIXEL_BITS-1:0] vin);
    logic [7:0][PIXEL_BITS-1:0] v;
    logic [PIXEL_BITS-1:0] t;
    logic [PIXEL_BITS:0] s;
    v = vin;
    for (int r = 0; r < 8; r++) begin
      for (int i = r % 2; i + 1 < 8; i += 2) begin
        if (v[i] > v[i+1]) begin
          t = v[i];
          v[i] = v[i+1];
          v[i+1] = t;
        end
      end
    end
    s = {1'b0, v[3]} + {1'b0, v[4]} + 1'b1;
    return s[PIXEL_BITS:1];
  endfunction

endpackage

// ----- rtl/hcpc_if.sv -----
// ----------------------------------------------------------------------------
// hcpc stream interfaces
// Valid/ready channels for input pixels and corrected result pixels.
// ----------------------------------------------------------------------------
interface hcpc_in_if;
  logic                 valid;
  logic                 ready;
  hcpc_pkg::pix_t       pixel;
  logic                 defect_flag;
  logic                 padding;
  modport source (output valid, pixel, defect_flag, padding, input ready);
  modport sink   (input valid, pixel, defect_flag, padding, output ready);
endinterface

interface hcpc_out_if;
  logic                 valid;
  logic                 ready;
  hcpc_pkg::pix_t       pixel_out;
  logic [1:0]           pixel_class;
  logic                 frame_last;
  modport source (output valid, pixel_out, pixel_class, frame_last, input ready);
  modport sink   (input valid, pixel_out, pixel_class, frame_last, output ready);
endinterface

// ----- rtl/hcpc_ram.sv -----
// ----------------------------------------------------------------------------
// hcpc_ram: generic single-write, single-read RAM
// Registered read; a read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module hcpc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hot_cold_pixel_corrector_top.sv -----
// ----------------------------------------------------------------------------
// hot_cold_pixel_corrector_top: streaming hot/cold/defect pixel corrector
// Four line buffers, 5x5 window, neighbour median or CFA mean replacement.
// ----------------------------------------------------------------------------
// One pixel beat is accepted every clock as long as the output side keeps
// up; each beat passes three register stages (line buffer read, window
// shift, correction) and results appear in raster order 2*W+2 beats after
// the pixel they belong to, so a frame must be followed by 2*W+2 padding
// beats. The line store is four RAM banks of MAX_WIDTH entries, one per
// line slot, all read at the current column each beat while the slot of
// the current row is written; the banks need no clearing pass. Each stage
// moves on as soon as the one after it is free, so with a finished result
// waiting at the output register input beats are still taken until stage
// 1 and the window stage are both full. Configuration must be written only
// while the pipe is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hot_cold_pixel_corrector_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [hcpc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [hcpc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  hcpc_in_if.sink                               pix_in,
  hcpc_out_if.source                            pix_out
);

  // configuration registers
  logic [1:0]                      mode;
  logic                            raw_cfa;
  logic [hcpc_pkg::FW_BITS-1:0]    frame_width;
  hcpc_pkg::row_t                  frame_height;
  hcpc_pkg::pix_t                  cold_threshold;
  hcpc_pkg::pix_t                  hot_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= hcpc_pkg::MODE_PASS;
      raw_cfa        <= 1'b0;
      frame_width    <= hcpc_pkg::FW_BITS'(4096);
      frame_height   <= hcpc_pkg::ROW_BITS'(4096);
      cold_threshold <= '0;
      hot_threshold  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcpc_pkg::REG_MODE:     mode           <= cfg_data[1:0];
        hcpc_pkg::REG_RAW_CFA:  raw_cfa        <= cfg_data[0];
        hcpc_pkg::REG_WIDTH:    frame_width    <= cfg_data[hcpc_pkg::FW_BITS-1:0];
        hcpc_pkg::REG_HEIGHT:   frame_height   <= cfg_data;
        hcpc_pkg::REG_COLD_THR: cold_threshold <= cfg_data;
        hcpc_pkg::REG_HOT_THR:  hot_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size: width clamped to [5, MAX_WIDTH], height at least 5
  logic [hcpc_pkg::FW_BITS-1:0] w_eff;
  hcpc_pkg::row_t               h_eff;

  always_comb begin
    if (frame_width < hcpc_pkg::FW_BITS'(5)) begin
      w_eff = hcpc_pkg::FW_BITS'(5);
    end else if (frame_width > hcpc_pkg::FW_BITS'(hcpc_pkg::MAX_WIDTH)) begin
      w_eff = hcpc_pkg::FW_BITS'(hcpc_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < hcpc_pkg::ROW_BITS'(5)) ? hcpc_pkg::ROW_BITS'(5) : frame_height;
  end

  // pipeline handshakes
  logic s1_v, s2_v, out_v;
  logic load1, load2, load3, ready3;

  assign ready3       = !out_v || pix_out.ready;
  assign load3        = s2_v && ready3;
  assign load2        = s1_v && (!s2_v || ready3);
  assign pix_in.ready = !s1_v || load2;
  assign load1        = pix_in.valid && pix_in.ready;

  // stage 0: position counters, all advanced at input accept
  hcpc_pkg::col_t ic, oc;
  hcpc_pkg::row_t ir, orow;
  hcpc_pkg::col_t ic_next, oc_next;
  hcpc_pkg::row_t ir_next, orow_next;
  hcpc_pkg::col_t col;
  hcpc_pkg::row_t row;
  hcpc_pkg::pos_t pos0;
  logic [hcpc_pkg::FW_BITS-1:0] col_inc, x_inc;
  logic [hcpc_pkg::ROW_BITS:0]  y_inc;
  hcpc_pkg::item_t item0;

  always_comb begin
    // wrap a column left beyond a narrowed width
    if ({1'b0, ic} >= w_eff) begin
      col = '0;
      row = ir + 1'b1;
    end else begin
      col = ic;
      row = ir;
    end
    col_inc = {1'b0, col} + 1'b1;
    if (col_inc >= w_eff) begin
      ic_next = '0;
      ir_next = row + 1'b1;
    end else begin
      ic_next = col_inc[hcpc_pkg::COL_BITS-1:0];
      ir_next = row;
    end

    pos0.emit = ((oc != '0) || (orow != '0))
             || (row >= hcpc_pkg::ROW_BITS'(2) && col >= hcpc_pkg::COL_BITS'(2));
    if ({1'b0, oc} >= w_eff) begin
      pos0.x = '0;
      pos0.y = orow + 1'b1;
    end else begin
      pos0.x = oc;
      pos0.y = orow;
    end
    x_inc     = {1'b0, pos0.x} + 1'b1;
    y_inc     = {1'b0, pos0.y} + 1'b1;
    pos0.last = (y_inc >= {1'b0, h_eff}) && (x_inc >= w_eff);

    oc_next   = oc;
    orow_next = orow;
    if (pos0.emit) begin
      if (pos0.last) begin
        // end of frame: every counter restarts
        ic_next   = '0;
        ir_next   = '0;
        oc_next   = '0;
        orow_next = '0;
      end else if (x_inc >= w_eff) begin
        oc_next   = '0;
        orow_next = y_inc[hcpc_pkg::ROW_BITS-1:0];
      end else begin
        oc_next   = x_inc[hcpc_pkg::COL_BITS-1:0];
      end
    end

    // padding beats go in as a zero sample with no flag
    item0 = pix_in.padding ? '0 : {pix_in.defect_flag, pix_in.pixel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic   <= '0;
      ir   <= '0;
      oc   <= '0;
      orow <= '0;
    end else if (load1) begin
      ic   <= ic_next;
      ir   <= ir_next;
      oc   <= oc_next;
      orow <= orow_next;
    end
  end

  // line store: one bank per line slot, read at the column, written in slot row&3
  hcpc_pkg::item_t bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    hcpc_ram #(
      .WIDTH (hcpc_pkg::ITEM_BITS),
      .DEPTH (hcpc_pkg::MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (load1 && (row[1:0] == 2'(b))),
      .waddr (col),
      .wdata (item0),
      .re    (load1),
      .raddr (col),
      .rdata (bank_rd[b])
    );
  end

  // stage 1: new sample and bookkeeping, bank data arrives alongside
  hcpc_pkg::item_t s1_item;
  logic [1:0]      s1_slot;
  hcpc_pkg::pos_t  s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (load1) begin
      s1_v <= 1'b1;
    end else if (load2) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_item <= item0;
      s1_slot <= row[1:0];
      s1_pos  <= pos0;
    end
  end

  // stage 2: the 5x5 window, shifted left by one column per beat
  hcpc_pkg::item_t win [5][5];
  hcpc_pkg::pos_t  s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (load2) begin
      s2_v <= 1'b1;
    end else if (load3) begin
      s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (load2) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      // window row i holds line row-4+i, found in bank (row+i)&3
      for (int i = 0; i < 4; i++) begin
        win[i][4] <= bank_rd[2'(s1_slot + 2'(i))];
      end
      win[4][4] <= s1_item;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_pos <= s1_pos;
    end
  end

  // stage 3: correction from original neighbours
  logic [7:0][hcpc_pkg::PIXEL_BITS-1:0] nb;
  hcpc_pkg::pix_t          cv, med, cfa, val;
  logic [1:0]              cls;
  logic [hcpc_pkg::PIXEL_BITS+1:0] cfa_sum;
  logic [hcpc_pkg::ROW_BITS:0]     xs, ys, ws, hs;
  logic                    inner2, inner1, cold, hot;

  always_comb begin
    nb[0] = win[1][1][hcpc_pkg::PIXEL_BITS-1:0];
    nb[1] = win[1][2][hcpc_pkg::PIXEL_BITS-1:0];
    nb[2] = win[1][3][hcpc_pkg::PIXEL_BITS-1:0];
    nb[3] = win[2][1][hcpc_pkg::PIXEL_BITS-1:0];
    nb[4] = win[2][3][hcpc_pkg::PIXEL_BITS-1:0];
    nb[5] = win[3][1][hcpc_pkg::PIXEL_BITS-1:0];
    nb[6] = win[3][2][hcpc_pkg::PIXEL_BITS-1:0];
    nb[7] = win[3][3][hcpc_pkg::PIXEL_BITS-1:0];
    med   = hcpc_pkg::median8(nb);

    // same-color neighbours two away, mean rounded half up
    cfa_sum = {2'b00, win[0][2][hcpc_pkg::PIXEL_BITS-1:0]}
            + {2'b00, win[4][2][hcpc_pkg::PIXEL_BITS-1:0]}
            + {2'b00, win[2][0][hcpc_pkg::PIXEL_BITS-1:0]}
            + {2'b00, win[2][4][hcpc_pkg::PIXEL_BITS-1:0]}
            + 2'd2;
    cfa     = cfa_sum[hcpc_pkg::PIXEL_BITS+1:2];

    cv = win[2][2][hcpc_pkg::PIXEL_BITS-1:0];
    xs = 17'(s2_pos.x);
    ys = 17'(s2_pos.y);
    ws = 17'(w_eff);
    hs = 17'(h_eff);
    inner2 = xs >= 17'd2 && ys >= 17'd2 && xs + 17'd2 < ws && ys + 17'd2 < hs;
    inner1 = xs >= 17'd1 && ys >= 17'd1 && xs + 17'd1 < ws && ys + 17'd1 < hs;
    cold   = cv < cold_threshold;
    hot    = cv > hot_threshold;

    val = cv;
    cls = hcpc_pkg::CLS_NONE;
    unique case (mode)
      hcpc_pkg::MODE_DEFECT: begin
        if (win[2][2][hcpc_pkg::PIXEL_BITS] && inner2) begin
          val = raw_cfa ? cfa : med;
          cls = hcpc_pkg::CLS_DEFECT;
        end
      end
      hcpc_pkg::MODE_SIGMA: begin
        // a pixel both cold and hot counts as cold
        if (inner1 && (cold || hot)) begin
          val = med;
          cls = cold ? hcpc_pkg::CLS_COLD : hcpc_pkg::CLS_HOT;
        end
      end
      default: ;
    endcase
  end

  // output register; beats before the first window center are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load3) begin
      out_v <= s2_pos.emit;
    end else if (pix_out.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      pix_out.pixel_out   <= val;
      pix_out.pixel_class <= cls;
      pix_out.frame_last  <= s2_pos.last;
    end
  end

  assign pix_out.valid = out_v;

endmodule
